// ===== sv/plg_pkg.sv =====
// ----------------------------------------------------------------------------
// Plugboard scan and substitute package
// Shared payload types, command type and constants of the plugboard unit.
// ----------------------------------------------------------------------------
package plg_pkg;

    // Default number of letters in the swap table.
    localparam int LETTERS_DEF = 26;
    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed field widths.
    localparam int OP_W    = 2;
    localparam int LINE_W  = 5;
    localparam int SENSE_W = 26;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 5;

    // Character constants.
    localparam logic [CHAR_W-1:0] CHAR_BASE = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

    // Operation codes of an input transaction.
    localparam logic [OP_W-1:0] OP_SCAN   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LINE_W-1:0]  driven_line;
        logic [SENSE_W-1:0] sense_lines;
        logic [CHAR_W-1:0]  query_char;
    } t_in;

    // Output transaction.
    typedef struct packed {
        logic [CHAR_W-1:0] mapped_char;
        logic [POS_W-1:0]  position;
        logic              last;
    } t_out;

    // Kind of command the back part carries out.
    typedef enum logic [1:0] {
        KIND_SCAN,
        KIND_LOOKUP,
        KIND_DUMP
    } t_kind;

    // Classified command passed from front to back.
    typedef struct packed {
        t_kind             kind;
        logic [POS_W-1:0]  idx_a;
        logic [POS_W-1:0]  idx_b;
        logic              found;
        logic              valid_char;
    } t_cmd;

endpackage

// ===== sv/plg_front.sv =====
// ----------------------------------------------------------------------------
// Plugboard front end
// Accepts input transactions, finds the scan partner and classifies lookups.
// ----------------------------------------------------------------------------
module plg_front #(
    parameter int LETTERS = plg_pkg::LETTERS_DEF
) (
    input  logic         i_in_valid,
    input  plg_pkg::t_in i_in_data,
    output logic         o_in_stall,
    input  logic         i_full,
    output logic         o_push,
    output plg_pkg::t_cmd o_cmd
);

    logic [plg_pkg::SENSE_W-1:0] letters_mask;
    logic [plg_pkg::SENSE_W-1:0] masked;
    logic [plg_pkg::SENSE_W-1:0] lowest;
    logic [plg_pkg::POS_W-1:0]   partner;
    logic [plg_pkg::CHAR_W-1:0]  q_off;
    logic                        char_ok;
    logic                        line_ok;
    logic                        keep;

    // Sense bits that name a real letter line.
    always_comb begin
        for (int k = 0; k < plg_pkg::SENSE_W; k++) begin
            letters_mask[k] = (k < LETTERS);
        end
    end

    // Drop the driven line itself and isolate the lowest remaining bit.
    assign masked = i_in_data.sense_lines & letters_mask
                    & ~({{(plg_pkg::SENSE_W-1){1'b0}}, 1'b1} << i_in_data.driven_line);
    assign lowest = masked & (~masked + {{(plg_pkg::SENSE_W-1){1'b0}}, 1'b1});

    // Encode the one-hot lowest bit into an index.
    always_comb begin
        partner = '0;
        for (int b = 0; b < plg_pkg::POS_W; b++) begin
            for (int k = 0; k < plg_pkg::SENSE_W; k++) begin
                if (((k >> b) & 1) == 1) begin
                    partner[b] = partner[b] | lowest[k];
                end
            end
        end
    end

    // Lookup range check against the table size.
    assign q_off   = i_in_data.query_char - plg_pkg::CHAR_BASE;
    assign char_ok = (i_in_data.query_char >= plg_pkg::CHAR_BASE)
                     && ({1'b0, q_off} < 9'(LETTERS));
    assign line_ok = ({1'b0, i_in_data.driven_line} < 6'(LETTERS));

    // Build the command; items without effect are accepted and dropped.
    always_comb begin
        o_cmd.kind       = plg_pkg::KIND_SCAN;
        o_cmd.idx_a      = i_in_data.driven_line;
        o_cmd.idx_b      = partner;
        o_cmd.found      = |masked;
        o_cmd.valid_char = char_ok;
        keep             = 1'b0;
        case (i_in_data.op)
            plg_pkg::OP_SCAN: begin
                keep = line_ok;
            end
            plg_pkg::OP_LOOKUP: begin
                o_cmd.kind  = plg_pkg::KIND_LOOKUP;
                o_cmd.idx_a = char_ok ? q_off[plg_pkg::POS_W-1:0] : '0;
                keep        = 1'b1;
            end
            plg_pkg::OP_DUMP: begin
                o_cmd.kind = plg_pkg::KIND_DUMP;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full && keep;

endmodule

// ===== sv/plg_queue.sv =====
// ----------------------------------------------------------------------------
// Plugboard command queue
// Small first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module plg_queue #(
    parameter int DEPTH = plg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  plg_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output plg_pkg::t_cmd o_data,
    input  logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    plg_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage; no reset needed.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/plg_back.sv =====
// ----------------------------------------------------------------------------
// Plugboard back end
// Holds the swap table and carries out scan, lookup and dump commands.
// ----------------------------------------------------------------------------
module plg_back #(
    parameter int LETTERS = plg_pkg::LETTERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  plg_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    output plg_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    localparam int IDX_W = $clog2(LETTERS);

    typedef enum logic {
        ST_CMD,
        ST_DUMP
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [plg_pkg::POS_W-1:0] r_table [LETTERS];
    logic [plg_pkg::POS_W-1:0] r_cnt;
    logic [plg_pkg::POS_W-1:0] n_cnt;
    logic                      r_out_valid;
    logic                      n_out_valid;
    plg_pkg::t_out             r_out;
    plg_pkg::t_out             n_out;
    logic                      can_load;
    logic                      scan_we;
    logic [plg_pkg::POS_W-1:0] rd_idx;
    logic [plg_pkg::POS_W-1:0] rd_entry;
    logic [plg_pkg::CHAR_W-1:0] rd_char;

    // Single table read port shared by lookup and dump.
    assign rd_idx   = (r_state == ST_DUMP) ? r_cnt : i_cmd.idx_a;
    assign rd_entry = r_table[rd_idx[IDX_W-1:0]];
    assign rd_char  = plg_pkg::CHAR_BASE + {3'b000, rd_entry};
    assign can_load = !r_out_valid || !i_out_stall;

    // Command sequencing and output register loading.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        scan_we     = 1'b0;
        case (r_state)
            ST_CMD: begin
                if (i_q_valid) begin
                    case (i_cmd.kind)
                        plg_pkg::KIND_SCAN: begin
                            o_pop   = 1'b1;
                            scan_we = 1'b1;
                        end
                        plg_pkg::KIND_LOOKUP: begin
                            if (can_load) begin
                                o_pop             = 1'b1;
                                n_out_valid       = 1'b1;
                                n_out.mapped_char = i_cmd.valid_char ? rd_char
                                                                     : plg_pkg::CHAR_NONE;
                                n_out.position    = i_cmd.idx_a;
                                n_out.last        = 1'b1;
                            end
                        end
                        plg_pkg::KIND_DUMP: begin
                            o_pop   = 1'b1;
                            n_state = ST_DUMP;
                            n_cnt   = '0;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (can_load) begin
                    n_out_valid       = 1'b1;
                    n_out.mapped_char = rd_char;
                    n_out.position    = r_cnt;
                    n_out.last        = (r_cnt == plg_pkg::POS_W'(LETTERS - 1));
                    n_cnt             = r_cnt + 1'b1;
                    if (n_out.last) begin
                        n_state = ST_CMD;
                    end
                end
            end
            default: begin
                n_state = ST_CMD;
            end
        endcase
    end

    // State, output register and swap table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CMD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LETTERS; i++) begin
                r_table[i] <= plg_pkg::POS_W'(i);
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (scan_we) begin
                r_table[i_cmd.idx_a[IDX_W-1:0]] <= i_cmd.found ? i_cmd.idx_b : i_cmd.idx_a;
                if (i_cmd.found) begin
                    r_table[i_cmd.idx_b[IDX_W-1:0]] <= i_cmd.idx_a;
                end
            end
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/plugboard_scan_and_substitute_unit.sv =====
// ----------------------------------------------------------------------------
// Plugboard scan and substitute unit
// Records plugboard pairings from line scans and substitutes letters.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  input     in         i_in_valid/o_in_stall   plg_pkg::t_in  (op, line, sense, char)
//  output    out        o_out_valid/i_out_stall plg_pkg::t_out (char, position, last)
//
// A scan or lookup transaction is taken every cycle while the command queue
// has room. A lookup result passes through the command queue and then the
// output register. A dump first takes the command, then reads one table entry
// per cycle through the single table read port, unless the output stalls.
// Reset is synchronous and restores the identity table at once.
// An output stall holds the output register; the queue then fills and stalls
// the input.
// ----------------------------------------------------------------------------
module plugboard_scan_and_substitute_unit #(
    parameter int LETTERS     = plg_pkg::LETTERS_DEF,
    parameter int QUEUE_DEPTH = plg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  plg_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output plg_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    logic          push;
    logic          full;
    logic          q_valid;
    logic          pop;
    plg_pkg::t_cmd front_cmd;
    plg_pkg::t_cmd back_cmd;

    // Front end: classification.
    plg_front #(
        .LETTERS(LETTERS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // Command queue.
    plg_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (back_cmd),
        .i_pop   (pop)
    );

    // Back end: table and result generation.
    plg_back #(
        .LETTERS(LETTERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // The queue is empty right after reset, so input is never stalled then.
    a_reset_ready : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // An invalid lookup reports position zero and is a final result.
    a_null_char : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.mapped_char == plg_pkg::CHAR_NONE)
        |-> (o_out_data.position == '0 && o_out_data.last))
        else $error("null character result with bad position or flag");

    // Within a dump, the next entry follows the taken one without a gap.
    a_dump_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last)
        |=> (o_out_valid
             && o_out_data.position == plg_pkg::POS_W'($past(o_out_data.position) + 1)))
        else $error("dump entry missing or out of order");

endmodule
